// ----- rtl/best_fit_block_allocator_defines.svh -----
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bfba_pkg.sv -----
`default_nettype none
package bfba_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam int SIZE_W  = 11;
    localparam int REQ_W   = 16;
    localparam int BLKO_W  = 10;

    typedef struct packed {
        logic       clr_en;
        logic       accept;
        logic       scan_clr;
        logic       blk_scan;
        logic       rec_scan;
        logic       alloc_wr;
        logic       rel_rd;
        logic       rel_wr;
        logic       res_load;
        logic [1:0] res_status;
    } dp_ctrl_t;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic fit_found;
        logic slot_found;
        logic hit_found;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/best_fit_block_allocator.sv -----
// Allocate scans the free-count memory and then the record memory, release scans
// only the record memory; a failing request ends right after the scan that fails.
// Throughput: one request at a time; the next is taken in the cycle after the result
// is loaded, and a held result delays that load. Both scans are sequential, one
// memory entry per cycle.
// Reset: async, active low; a clear of both memories precedes in_ready.
`default_nettype none
module best_fit_block_allocator #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 1024,
    parameter int MAX_RECORDS = 256,
    parameter int ID_BITS     = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [15:0] request_id,
    input  wire logic [10:0] alloc_size,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [9:0]       block_index,
    output logic [10:0]      moved_size,
    output logic [15:0]      echo_request
);

    bfba_pkg::dp_ctrl_t ctrl;
    bfba_pkg::dp_stat_t stat;

    bfba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bfba_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_RECORDS (MAX_RECORDS),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .in_cmd       (cmd),
        .request_id   (request_id),
        .alloc_size   (alloc_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .block_index  (block_index),
        .moved_size   (moved_size),
        .echo_request (echo_request)
    );

`include "best_fit_block_allocator_defines.svh"

    `BFBA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `BFBA_ASSERT_NOW(a_fail_zero, out_valid && status != bfba_pkg::ST_OK, block_index == 10'd0 && moved_size == 11'd0, "failure result carries data")
    `BFBA_ASSERT_NOW(a_alloc_wr_ok, ctrl.alloc_wr, stat.fit_found && stat.slot_found, "commit without fit and slot")
    `BFBA_ASSERT_NOW(a_load_free, ctrl.res_load, !stat.out_busy, "result overwrites pending output")

endmodule
`default_nettype wire

// ----- rtl/bfba_ctrl.sv -----
`default_nettype none
module bfba_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_cmd,
    output logic                   in_ready,
    input  wire bfba_pkg::dp_stat_t stat,
    output bfba_pkg::dp_ctrl_t     ctrl
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_BSCAN, S_RSCAN, S_ALLOC_WR, S_REL_RD, S_REL_WR, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] res_reg, res_next;
    logic       rel_reg, rel_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        rel_next   = rel_reg;
        ctrl       = '0;
        ctrl.res_status = res_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_en = 1'b1;
                if (stat.clr_done)
                begin
                    ctrl.scan_clr = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.accept   = 1'b1;
                    ctrl.scan_clr = 1'b1;
                    rel_next      = (in_cmd == bfba_pkg::CMD_RELEASE);
                    state_next    = (in_cmd == bfba_pkg::CMD_RELEASE) ? S_RSCAN : S_BSCAN;
                end
            end
            S_BSCAN:
            begin
                ctrl.blk_scan = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.fit_found)
                    begin
                        ctrl.scan_clr = 1'b1;
                        state_next    = S_RSCAN;
                    end
                    else
                    begin
                        res_next   = bfba_pkg::ST_NOFIT;
                        state_next = S_DONE;
                    end
                end
            end
            S_RSCAN:
            begin
                ctrl.rec_scan = 1'b1;
                if (stat.scan_done)
                begin
                    if (rel_reg)
                    begin
                        if (stat.hit_found)
                            state_next = S_REL_RD;
                        else
                        begin
                            res_next   = bfba_pkg::ST_NOTFOUND;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        if (stat.slot_found)
                            state_next = S_ALLOC_WR;
                        else
                        begin
                            res_next   = bfba_pkg::ST_FULL;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_ALLOC_WR:
            begin
                ctrl.alloc_wr = 1'b1;
                res_next      = bfba_pkg::ST_OK;
                state_next    = S_DONE;
            end
            S_REL_RD:
            begin
                ctrl.rel_rd = 1'b1;
                state_next  = S_REL_WR;
            end
            S_REL_WR:
            begin
                ctrl.rel_wr = 1'b1;
                res_next    = bfba_pkg::ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.res_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            res_reg   <= bfba_pkg::ST_OK;
            rel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            rel_reg   <= rel_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bfba_dp.sv -----
`default_nettype none
module bfba_dp #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 1024,
    parameter int MAX_RECORDS = 256,
    parameter int ID_BITS     = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bfba_pkg::dp_ctrl_t                ctrl,
    output bfba_pkg::dp_stat_t                     stat,
    input  wire logic                              in_cmd,
    input  wire logic [bfba_pkg::REQ_W-1:0]        request_id,
    input  wire logic [bfba_pkg::SIZE_W-1:0]       alloc_size,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             status,
    output logic [bfba_pkg::BLKO_W-1:0]            block_index,
    output logic [bfba_pkg::SIZE_W-1:0]            moved_size,
    output logic [bfba_pkg::REQ_W-1:0]             echo_request
);

    localparam int SIZE_W = bfba_pkg::SIZE_W;
    localparam int REQ_W  = bfba_pkg::REQ_W;
    localparam int BLKO_W = bfba_pkg::BLKO_W;
    localparam int CLR_N  = (NUM_BLOCKS > MAX_RECORDS) ? NUM_BLOCKS : MAX_RECORDS;
    localparam int CNT_W  = $clog2(CLR_N + 1);
    localparam int BI_W   = $clog2(NUM_BLOCKS);
    localparam int RI_W   = $clog2(MAX_RECORDS);
    localparam int FB_W   = $clog2(BLOCK_BYTES + 1);
    localparam int CW     = (FB_W > SIZE_W) ? FB_W : SIZE_W;
    localparam int REC_W  = 1 + REQ_W + BI_W + SIZE_W;
    localparam logic [REQ_W-1:0] KEY_MASK =
        (ID_BITS >= REQ_W) ? {REQ_W{1'b1}} : REQ_W'((64'd1 << ID_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] NB_LIM  = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0] MR_LIM  = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CLR_END = CNT_W'(CLR_N - 1);

    logic [FB_W-1:0]  free_mem [NUM_BLOCKS];
    logic [REC_W-1:0] rec_mem  [MAX_RECORDS];

    logic [FB_W-1:0]   fr_q;
    logic [REC_W-1:0]  rc_q;
    logic              fr_we, rc_we;
    logic [BI_W-1:0]   fr_wa, fr_ra;
    logic [RI_W-1:0]   rc_wa;
    logic [FB_W-1:0]   fr_wd;
    logic [REC_W-1:0]  rc_wd;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pv_reg, pv_next;
    logic [CNT_W-1:0]  pi_reg, pi_next;
    logic [CNT_W-1:0]  lim;

    logic              cmd_reg, cmd_next;
    logic [REQ_W-1:0]  key_reg, key_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    logic              fit_reg, fit_next;
    logic [BI_W-1:0]   best_reg, best_next;
    logic [FB_W-1:0]   bval_reg, bval_next;
    logic              slot_f_reg, slot_f_next;
    logic [RI_W-1:0]   slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic [RI_W-1:0]   hidx_reg, hidx_next;
    logic [BI_W-1:0]   hblk_reg, hblk_next;
    logic [SIZE_W-1:0] hsz_reg, hsz_next;

    logic              ov_reg, ov_next;
    logic [1:0]        ost_reg, ost_next;
    logic [BI_W-1:0]   oblk_reg, oblk_next;
    logic [SIZE_W-1:0] osz_reg, osz_next;
    logic [REQ_W-1:0]  orq_reg, orq_next;

    logic              rc_valid;
    logic [REQ_W-1:0]  rc_req;
    logic [BI_W-1:0]   rc_blk;
    logic [SIZE_W-1:0] rc_size;
    logic [BI_W+BLKO_W-1:0] blk_ext;

    assign {rc_valid, rc_req, rc_blk, rc_size} = rc_q;

    always_ff @(posedge clk)
    begin
        if (fr_we)
            free_mem[fr_wa] <= fr_wd;
        fr_q <= free_mem[fr_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rc_we)
            rec_mem[rc_wa] <= rc_wd;
        rc_q <= rec_mem[cnt_reg[RI_W-1:0]];
    end

    always_comb
    begin
        lim      = ctrl.blk_scan ? NB_LIM : MR_LIM;
        cnt_next = cnt_reg;
        pv_next  = 1'b0;
        pi_next  = pi_reg;
        if (ctrl.scan_clr)
            cnt_next = '0;
        else if (ctrl.clr_en)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (ctrl.blk_scan || ctrl.rec_scan)
        begin
            pv_next = (cnt_reg < lim);
            pi_next = cnt_reg;
            if (cnt_reg < lim)
                cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        cmd_next  = cmd_reg;
        key_next  = key_reg;
        size_next = size_reg;
        fit_next    = fit_reg;
        best_next   = best_reg;
        bval_next   = bval_reg;
        slot_f_next = slot_f_reg;
        slot_next   = slot_reg;
        hit_next    = hit_reg;
        hidx_next   = hidx_reg;
        hblk_next   = hblk_reg;
        hsz_next    = hsz_reg;
        if (ctrl.accept)
        begin
            cmd_next    = in_cmd;
            key_next    = request_id & KEY_MASK;
            size_next   = alloc_size;
            fit_next    = 1'b0;
            slot_f_next = 1'b0;
            hit_next    = 1'b0;
        end
        if (ctrl.blk_scan && pv_reg)
        begin
            if ((CW'(fr_q) >= CW'(size_reg)) && (!fit_reg || fr_q < bval_reg))
            begin
                fit_next  = 1'b1;
                best_next = pi_reg[BI_W-1:0];
                bval_next = fr_q;
            end
        end
        if (ctrl.rec_scan && pv_reg)
        begin
            if (!rc_valid && !slot_f_reg)
            begin
                slot_f_next = 1'b1;
                slot_next   = pi_reg[RI_W-1:0];
            end
            if (rc_valid && rc_req == key_reg && !hit_reg)
            begin
                hit_next  = 1'b1;
                hidx_next = pi_reg[RI_W-1:0];
                hblk_next = rc_blk;
                hsz_next  = rc_size;
            end
        end
    end

    always_comb
    begin
        fr_we = 1'b0;
        fr_wa = best_reg;
        fr_wd = FB_W'(BLOCK_BYTES);
        fr_ra = cnt_reg[BI_W-1:0];
        rc_we = 1'b0;
        rc_wa = slot_reg;
        rc_wd = {1'b1, key_reg, best_reg, size_reg};
        if (ctrl.rel_rd)
            fr_ra = hblk_reg;
        if (ctrl.clr_en)
        begin
            fr_we = (cnt_reg < NB_LIM);
            fr_wa = cnt_reg[BI_W-1:0];
            rc_we = (cnt_reg < MR_LIM);
            rc_wa = cnt_reg[RI_W-1:0];
            rc_wd = '0;
        end
        else if (ctrl.alloc_wr)
        begin
            fr_we = 1'b1;
            fr_wd = FB_W'(CW'(bval_reg) - CW'(size_reg));
            rc_we = 1'b1;
        end
        else if (ctrl.rel_wr)
        begin
            fr_we = 1'b1;
            fr_wa = hblk_reg;
            fr_wd = FB_W'(CW'(fr_q) + CW'(hsz_reg));
            rc_we = 1'b1;
            rc_wa = hidx_reg;
            rc_wd = '0;
        end
    end

    always_comb
    begin
        ov_next   = ov_reg && !out_ready;
        ost_next  = ost_reg;
        oblk_next = oblk_reg;
        osz_next  = osz_reg;
        orq_next  = orq_reg;
        if (ctrl.res_load)
        begin
            ov_next  = 1'b1;
            ost_next = ctrl.res_status;
            orq_next = key_reg;
            if (ctrl.res_status != bfba_pkg::ST_OK)
            begin
                oblk_next = '0;
                osz_next  = '0;
            end
            else if (cmd_reg == bfba_pkg::CMD_RELEASE)
            begin
                oblk_next = hblk_reg;
                osz_next  = hsz_reg;
            end
            else
            begin
                oblk_next = best_reg;
                osz_next  = size_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            fit_reg    <= 1'b0;
            slot_f_reg <= 1'b0;
            hit_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            cmd_reg    <= bfba_pkg::CMD_ALLOC;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            pv_reg     <= pv_next;
            fit_reg    <= fit_next;
            slot_f_reg <= slot_f_next;
            hit_reg    <= hit_next;
            ov_reg     <= ov_next;
            cmd_reg    <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg   <= pi_next;
        key_reg  <= key_next;
        size_reg <= size_next;
        best_reg <= best_next;
        bval_reg <= bval_next;
        slot_reg <= slot_next;
        hidx_reg <= hidx_next;
        hblk_reg <= hblk_next;
        hsz_reg  <= hsz_next;
        ost_reg  <= ost_next;
        oblk_reg <= oblk_next;
        osz_reg  <= osz_next;
        orq_reg  <= orq_next;
    end

    assign stat.clr_done   = ctrl.clr_en && (cnt_reg == CLR_END);
    assign stat.scan_done  = (cnt_reg == lim) && !pv_reg;
    assign stat.fit_found  = fit_reg;
    assign stat.slot_found = slot_f_reg;
    assign stat.hit_found  = hit_reg;
    assign stat.out_busy   = ov_reg && !out_ready;

    assign blk_ext      = {{BLKO_W{1'b0}}, oblk_reg};
    assign out_valid    = ov_reg;
    assign status       = ost_reg;
    assign block_index  = blk_ext[BLKO_W-1:0];
    assign moved_size   = osz_reg;
    assign echo_request = orq_reg;

endmodule
`default_nettype wire
